FILE: sv/dmr_pkg.sv
// Shared types and constants for the push-button dimmer controller.
package dmr_pkg;

  // Default full-on level in percent.
  localparam int unsigned MAX_LEVEL_DEF = 100;

  // Width of the requested level field and of the duty output.
  localparam int unsigned REQ_W    = 8;
  localparam int unsigned DUTY_W   = 8;
  localparam int unsigned BRIGHT_W = 7;

  // Duty scaling: (level * 256 - 100) / 100, with a reciprocal multiply.
  localparam int unsigned DUTY_BIAS   = 100;
  localparam int unsigned DUTY_DIV    = 100;
  localparam int unsigned RECIP_SHIFT = 23;
  localparam int unsigned RECIP_MULT  = ((2 ** RECIP_SHIFT) + DUTY_DIV - 1) / DUTY_DIV;
  localparam int unsigned RECIP_W     = $clog2(RECIP_MULT + 1);
  localparam logic [DUTY_W-1:0] DUTY_FULL = 8'hFF;

  typedef enum logic [2:0] {
    OP_PRESS   = 3'd0,
    OP_LONG    = 3'd1,
    OP_REPEAT  = 3'd2,
    OP_RELEASE = 3'd3,
    OP_SET     = 3'd4,
    OP_RESET   = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    DIR_NONE = 2'd0,
    DIR_UP   = 2'd1,
    DIR_DOWN = 2'd2
  } dir_e;

  // Per-event flags handed from the core to the output register.
  typedef struct packed {
    logic changed;
    logic report;
  } evt_flags_t;

endpackage

FILE: sv/dmr_core.sv
// Dimmer state registers and the per-event level update.
module dmr_core import dmr_pkg::*; #(
  parameter int unsigned MaxLevel = MAX_LEVEL_DEF,
  parameter int unsigned LevelW   = $clog2(MAX_LEVEL_DEF + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [2:0]        op_i,
  input  logic [REQ_W-1:0]  req_i,
  output logic [LevelW-1:0] level_o,
  output evt_flags_t        flags_o
);

  localparam logic [LevelW-1:0] LvlMax  = LevelW'(MaxLevel);
  localparam logic [LevelW-1:0] LvlZero = '0;

  logic [LevelW-1:0] cur_q, cur_d;
  logic [LevelW-1:0] prev_q, prev_d;
  logic [LevelW-1:0] lbr_q, lbr_d;
  dir_e              dir_q, dir_d;

  logic [LevelW-1:0] cur_up, cur_dn, req_sat;
  logic              report;

  assign cur_up  = (cur_q < LvlMax) ? LevelW'(cur_q + 1'b1) : cur_q;
  assign cur_dn  = (cur_q != LvlZero) ? LevelW'(cur_q - 1'b1) : cur_q;
  assign req_sat = (req_i > REQ_W'(MaxLevel)) ? LvlMax : LevelW'(req_i);

  always_comb begin
    cur_d  = cur_q;
    prev_d = prev_q;
    lbr_d  = lbr_q;
    dir_d  = dir_q;
    report = 1'b0;
    case (op_e'(op_i))
      OP_PRESS: begin
        dir_d = DIR_NONE;
      end
      OP_LONG: begin
        lbr_d = cur_q;
        // Ramp toward the remembered level, or down when above it.
        if (prev_q >= cur_q) begin
          dir_d = DIR_UP;
          cur_d = cur_up;
        end else begin
          dir_d = DIR_DOWN;
          cur_d = cur_dn;
        end
      end
      OP_REPEAT: begin
        case (dir_q)
          DIR_UP:   cur_d = cur_up;
          DIR_DOWN: cur_d = cur_dn;
          default:  cur_d = cur_q;
        endcase
      end
      OP_RELEASE: begin
        report = 1'b1;
        if (dir_q == DIR_NONE) begin
          // Short press toggles between off and the remembered level.
          if (cur_q == LvlZero) begin
            prev_d = LvlZero;
            cur_d  = (prev_q != LvlZero) ? prev_q : LvlMax;
          end else begin
            prev_d = cur_q;
            cur_d  = LvlZero;
          end
        end else begin
          prev_d = lbr_q;
        end
      end
      OP_SET: begin
        report = 1'b1;
        if (req_sat != cur_q) begin
          prev_d = cur_q;
          cur_d  = req_sat;
        end
      end
      OP_RESET: begin
        cur_d  = LvlZero;
        prev_d = LvlMax;
        dir_d  = DIR_NONE;
        lbr_d  = LvlZero;
      end
      default: begin
        cur_d = cur_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q  <= LvlZero;
      prev_q <= LvlMax;
      lbr_q  <= LvlZero;
      dir_q  <= DIR_NONE;
    end else if (accept_i) begin
      cur_q  <= cur_d;
      prev_q <= prev_d;
      lbr_q  <= lbr_d;
      dir_q  <= dir_d;
    end
  end

  assign level_o         = cur_d;
  assign flags_o.report  = report;
  assign flags_o.changed = (cur_d != cur_q);

endmodule

FILE: sv/dmr_duty.sv
// Level-to-PWM compare value conversion with optional inversion.
module dmr_duty import dmr_pkg::*; #(
  parameter int unsigned LevelW = $clog2(MAX_LEVEL_DEF + 1)
) (
  input  logic [LevelW-1:0] level_i,
  input  logic              invert_i,
  output logic [DUTY_W-1:0] duty_o
);

  localparam int unsigned XW    = LevelW + 8;
  localparam int unsigned ProdW = XW + RECIP_W;
  localparam int unsigned QW    = ProdW - RECIP_SHIFT;

  logic [XW-1:0]    x, xm;
  logic [ProdW-1:0] prod;
  logic [QW-1:0]    quo;
  logic [DUTY_W-1:0] sat;

  assign x  = {level_i, 8'h00};
  assign xm = (x != '0) ? XW'(x - XW'(DUTY_BIAS)) : x;

  // Divide by 100 through a reciprocal; exact for every value below 2^16.
  assign prod = ProdW'(xm) * ProdW'(RECIP_MULT);
  assign quo  = prod[ProdW-1:RECIP_SHIFT];
  assign sat  = (quo > QW'(DUTY_FULL)) ? DUTY_FULL : DUTY_W'(quo);

  assign duty_o = invert_i ? (DUTY_FULL - sat) : sat;

endmodule

FILE: sv/push_button_dimmer_controller.sv
// Top level of the push-button dimmer controller.
//
// Input stream (s_axis): one transaction per key or command event. tuser carries
// the operation code, tdata the requested level for a set command.
// Output stream (m_axis): one transaction per event with the resulting brightness
// and PWM compare value in tdata, and the report and changed flags in tuser.
// Configuration channel (cfg): a single bit that selects inverted PWM drive;
// it is always ready and should be written only while no event is in flight.
//
// The state update and duty conversion are combinational, so a result is in the
// output register the cycle after its event is accepted. Throughput is one event
// per cycle while the receiver is ready, set by the single output register, which
// refills in the same cycle it drains. When the receiver stalls, the output
// register holds its result and s_axis_tready drops until the result is taken.
//
// Reset clears the level to off, the remembered level to full on, drops any
// ramp, and sets PWM inversion on. The reset command does the same except that
// inversion keeps its configured value.
module push_button_dimmer_controller import dmr_pkg::*; #(
  parameter int unsigned MaxLevel = MAX_LEVEL_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] level
  input  logic [2:0]  s_axis_tuser,   // [2:0] operation

  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [6:0] brightness, [14:7] pwm_duty, [15] zero
  output logic [1:0]  m_axis_tuser,   // [0] report, [1] changed

  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_data_i
);

  localparam int unsigned LevelW = $clog2(MaxLevel + 1);

  logic              in_accept;
  logic [LevelW-1:0] level;
  evt_flags_t        flags;
  logic [DUTY_W-1:0] duty;

  logic                invert_q;
  logic                out_valid_q;
  logic [BRIGHT_W-1:0] bright_q;
  logic [DUTY_W-1:0]   duty_q;
  evt_flags_t          flags_q;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  dmr_core #(
    .MaxLevel(MaxLevel),
    .LevelW  (LevelW)
  ) u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .accept_i(in_accept),
    .op_i    (s_axis_tuser),
    .req_i   (s_axis_tdata),
    .level_o (level),
    .flags_o (flags)
  );

  dmr_duty #(
    .LevelW(LevelW)
  ) u_duty (
    .level_i (level),
    .invert_i(invert_q),
    .duty_o  (duty)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      invert_q <= 1'b1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      invert_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      out_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      bright_q <= BRIGHT_W'(level);
      duty_q   <= duty;
      flags_q  <= flags;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, duty_q, bright_q};
  assign m_axis_tuser  = {flags_q.changed, flags_q.report};

endmodule
